// File: hw/rtl/tcd_pkg.sv
package tcd_pkg;

  // coordinate handling
  localparam int COORD_WIDTH = 16;
  localparam int FIELD_W     = 16;
  localparam int EFF_W       = (COORD_WIDTH < FIELD_W) ? COORD_WIDTH : FIELD_W;

  // datapath widths
  localparam int DIFF_W  = FIELD_W + 1;      // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;       // product of two differences
  localparam int CROSS_W = PROD_W + 1;       // edge value / normal component
  localparam int TERM_W  = CROSS_W + DIFF_W; // normal times difference
  localparam int NUM_W   = TERM_W + 2;       // sum of three terms
  localparam int MAG_W   = NUM_W;            // |num|
  localparam int DEN_W   = CROSS_W;          // |nz|
  localparam int DEPTH_W = 16;
  localparam int Q_W     = DEPTH_W;          // quotient bits resolved by the divider

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3 * FIELD_W;

  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C = CFG_IDX_W'(2);

  // saturation limits, raw Q8.8
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
  } pix_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } vtx_t;

  typedef struct packed {
    logic                      covered;
    logic signed [CROSS_W-1:0] nx;
    logic signed [CROSS_W-1:0] ny;
    logic signed [CROSS_W-1:0] nz;
    logic signed [DIFF_W-1:0]  dxa;
    logic signed [DIFF_W-1:0]  dya;
    logic signed [FIELD_W-1:0] az;
  } setup_t;

  typedef struct packed {
    logic             covered;
    logic             nz_zero;
    logic             neg;
    logic [MAG_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
  } plane_t;

  typedef struct packed {
    logic covered;
    logic nz_zero;
    logic neg;
    logic ovf;
  } div_flags_t;

  typedef struct packed {
    logic               covered;
    logic               degenerate;
    logic [DEPTH_W-1:0] depth;
  } result_t;

  function automatic logic signed [FIELD_W-1:0] sext_coord(input logic [FIELD_W-1:0] v);
    return FIELD_W'($signed(v[EFF_W-1:0]));
  endfunction

  function automatic vtx_t unpack_vertex(input logic [CFG_DATA_W-1:0] r);
    vtx_t v;
    v.x = sext_coord(r[FIELD_W-1:0]);
    v.y = sext_coord(r[2*FIELD_W-1:FIELD_W]);
    v.z = sext_coord(r[3*FIELD_W-1:2*FIELD_W]);
    return v;
  endfunction

  function automatic logic signed [DIFF_W-1:0] sdiff(input logic signed [FIELD_W-1:0] a,
                                                     input logic signed [FIELD_W-1:0] b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(input logic signed [DIFF_W-1:0] a,
                                                    input logic signed [DIFF_W-1:0] b);
    return PROD_W'(a) * PROD_W'(b);
  endfunction

endpackage

// File: hw/rtl/triangle_coverage_depth_top.sv
// Triangle coverage and plane depth, one pixel query per item.
//
// Config: cfg_we writes cfg_data (x 15:0, y 31:16, z 47:32, signed Q8.8)
//   into vertex a, b or c by cfg_index; other indexes are dropped. Write
//   only while no item is in flight.
// Input: in_valid/in_ready carry pixel_x, pixel_y (signed Q8.8).
// Output: out_valid/out_ready carry inside_res, depth (signed Q8.8,
//   truncated toward zero, saturated) and degenerate (inside with nz == 0).
//
// Stages: 2 setup stages (edge and normal products), 3 plane stages
//   (terms, sum, magnitudes), 17 divider stages (range check plus one
//   restoring quotient bit per stage) and the output register.
// Throughput: one item per cycle while the output is not stalled; each
//   divider stage resolves one bit, and nothing is shared between items.
// Stall: every stage has its own valid bit and loads when it is empty or
//   its successor moves, so bubbles close up and the input keeps taking
//   items while a result waits, until the whole pipeline is full.
// Reset: synchronous rst_n clears all valid bits and the vertex registers.
module triangle_coverage_depth_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tcd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [tcd_pkg::FIELD_W-1:0] in_pixel_x,
  input  logic signed [tcd_pkg::FIELD_W-1:0] in_pixel_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_inside_res,
  output logic signed [tcd_pkg::DEPTH_W-1:0] out_depth,
  output logic                              out_degenerate
);

  // vertex registers
  logic [tcd_pkg::CFG_DATA_W-1:0] vertex_a_r, vertex_b_r, vertex_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_a_r <= '0;
      vertex_b_r <= '0;
      vertex_c_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcd_pkg::REG_VERTEX_A: vertex_a_r <= cfg_data;
        tcd_pkg::REG_VERTEX_B: vertex_b_r <= cfg_data;
        tcd_pkg::REG_VERTEX_C: vertex_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  tcd_pkg::pix_t    pix;
  tcd_pkg::setup_t  setup_data;
  tcd_pkg::plane_t  plane_data;
  tcd_pkg::result_t div_res;
  logic             setup_valid, setup_ready;
  logic             plane_valid, plane_ready;
  logic             div_valid, div_ready;

  assign pix.x = in_pixel_x;
  assign pix.y = in_pixel_y;

  tcd_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .vertex_a  (vertex_a_r),
    .vertex_b  (vertex_b_r),
    .vertex_c  (vertex_c_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pix    (pix),
    .out_valid (setup_valid),
    .out_ready (setup_ready),
    .out_data  (setup_data)
  );

  tcd_plane u_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (setup_valid),
    .in_ready  (setup_ready),
    .in_data   (setup_data),
    .out_valid (plane_valid),
    .out_ready (plane_ready),
    .out_data  (plane_data)
  );

  tcd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (plane_valid),
    .in_ready  (plane_ready),
    .in_data   (plane_data),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_res)
  );

  // output register
  logic             out_valid_r;
  tcd_pkg::result_t out_res_r;

  assign div_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (div_ready) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_ready) begin
      out_res_r <= div_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = out_res_r.covered;
  assign out_depth      = $signed(out_res_r.depth);
  assign out_degenerate = out_res_r.degenerate;

  // flat normal: point is covered and depth is forced to zero
  a_degen_inside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.degenerate |-> out_res_r.covered && (out_res_r.depth == '0))
    else $error("degenerate item not inside or with nonzero depth");

  a_outside_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_res_r.covered |-> !out_res_r.degenerate && (out_res_r.depth == '0))
    else $error("outside item carries depth or degenerate flag");

  // input only backs up when the output register is held
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid_r && !out_ready)
    else $error("input stalled without an output stall");

endmodule

// File: hw/rtl/tcd_setup.sv
// Two stages: edge and normal partial products, then differences and coverage.
module tcd_setup (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]    vertex_a,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]    vertex_b,
  input  logic [tcd_pkg::CFG_DATA_W-1:0]    vertex_c,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tcd_pkg::pix_t                     in_pix,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tcd_pkg::setup_t                   out_data
);

  tcd_pkg::vtx_t a, b, c;
  logic signed [tcd_pkg::FIELD_W-1:0] px, py;
  logic signed [tcd_pkg::DIFF_W-1:0]  e1x, e1y, e1z, e2x, e2y, e2z;

  // index 0..2: edge values, 3..5: normal x, y, z
  logic signed [tcd_pkg::PROD_W-1:0]  pa_nxt [6];
  logic signed [tcd_pkg::PROD_W-1:0]  pb_nxt [6];
  logic signed [tcd_pkg::PROD_W-1:0]  pa_r   [6];
  logic signed [tcd_pkg::PROD_W-1:0]  pb_r   [6];
  logic signed [tcd_pkg::DIFF_W-1:0]  dxa_r, dya_r;
  logic signed [tcd_pkg::FIELD_W-1:0] az_r;

  logic signed [tcd_pkg::CROSS_W-1:0] dif [6];
  logic                               any_neg, any_pos;
  tcd_pkg::setup_t                    data_nxt, data_r;

  logic [1:0] v_r;
  logic       en0, en1;

  assign en1       = !v_r[1] || out_ready;
  assign en0       = !v_r[0] || en1;
  assign in_ready  = en0;
  assign out_valid = v_r[1];
  assign out_data  = data_r;

  assign a  = tcd_pkg::unpack_vertex(vertex_a);
  assign b  = tcd_pkg::unpack_vertex(vertex_b);
  assign c  = tcd_pkg::unpack_vertex(vertex_c);
  assign px = tcd_pkg::sext_coord(in_pix.x);
  assign py = tcd_pkg::sext_coord(in_pix.y);

  assign e1x = tcd_pkg::sdiff(b.x, a.x);
  assign e1y = tcd_pkg::sdiff(b.y, a.y);
  assign e1z = tcd_pkg::sdiff(b.z, a.z);
  assign e2x = tcd_pkg::sdiff(c.x, a.x);
  assign e2y = tcd_pkg::sdiff(c.y, a.y);
  assign e2z = tcd_pkg::sdiff(c.z, a.z);

  always_comb begin
    // edge a->b, b->c, c->a
    pa_nxt[0] = tcd_pkg::smul(tcd_pkg::sdiff(px, b.x), tcd_pkg::sdiff(a.y, b.y));
    pb_nxt[0] = tcd_pkg::smul(tcd_pkg::sdiff(a.x, b.x), tcd_pkg::sdiff(py, b.y));
    pa_nxt[1] = tcd_pkg::smul(tcd_pkg::sdiff(px, c.x), tcd_pkg::sdiff(b.y, c.y));
    pb_nxt[1] = tcd_pkg::smul(tcd_pkg::sdiff(b.x, c.x), tcd_pkg::sdiff(py, c.y));
    pa_nxt[2] = tcd_pkg::smul(tcd_pkg::sdiff(px, a.x), tcd_pkg::sdiff(c.y, a.y));
    pb_nxt[2] = tcd_pkg::smul(tcd_pkg::sdiff(c.x, a.x), tcd_pkg::sdiff(py, a.y));
    // n = e1 x e2
    pa_nxt[3] = tcd_pkg::smul(e1y, e2z);
    pb_nxt[3] = tcd_pkg::smul(e1z, e2y);
    pa_nxt[4] = tcd_pkg::smul(e1z, e2x);
    pb_nxt[4] = tcd_pkg::smul(e1x, e2z);
    pa_nxt[5] = tcd_pkg::smul(e1x, e2y);
    pb_nxt[5] = tcd_pkg::smul(e1y, e2x);
  end

  always_ff @(posedge clk) begin
    if (en0) begin
      for (int k = 0; k < 6; k++) begin
        pa_r[k] <= pa_nxt[k];
        pb_r[k] <= pb_nxt[k];
      end
      dxa_r <= tcd_pkg::sdiff(a.x, px);
      dya_r <= tcd_pkg::sdiff(a.y, py);
      az_r  <= a.z;
    end
  end

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      dif[k] = tcd_pkg::CROSS_W'(pa_r[k]) - tcd_pkg::CROSS_W'(pb_r[k]);
    end
    any_neg = 1'b0;
    any_pos = 1'b0;
    for (int k = 0; k < 3; k++) begin
      any_neg = any_neg | dif[k][tcd_pkg::CROSS_W-1];
      any_pos = any_pos | (!dif[k][tcd_pkg::CROSS_W-1] && (dif[k] != '0));
    end
    data_nxt.covered = !(any_neg && any_pos);
    data_nxt.nx      = dif[3];
    data_nxt.ny      = dif[4];
    data_nxt.nz      = dif[5];
    data_nxt.dxa     = dxa_r;
    data_nxt.dya     = dya_r;
    data_nxt.az      = az_r;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en0) begin
        v_r[0] <= in_valid;
      end
      if (en1) begin
        v_r[1] <= v_r[0];
      end
    end
  end

endmodule

// File: hw/rtl/tcd_plane.sv
// Three stages: plane terms, numerator sum, magnitudes and quotient sign.
module tcd_plane (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  tcd_pkg::setup_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output tcd_pkg::plane_t out_data
);

  logic signed [tcd_pkg::TERM_W-1:0] t0_r, t1_r, t2_r;
  logic                              ins0_r, nzz0_r, nzneg0_r;
  logic [tcd_pkg::DEN_W-1:0]         den0_r;

  logic signed [tcd_pkg::NUM_W-1:0]  num_r;
  logic                              ins1_r, nzz1_r, nzneg1_r;
  logic [tcd_pkg::DEN_W-1:0]         den1_r;

  tcd_pkg::plane_t                   data_r;

  logic [2:0] v_r;
  logic       en0, en1, en2;

  assign en2       = !v_r[2] || out_ready;
  assign en1       = !v_r[1] || en2;
  assign en0       = !v_r[0] || en1;
  assign in_ready  = en0;
  assign out_valid = v_r[2];
  assign out_data  = data_r;

  // num = nx*(ax-px) + ny*(ay-py) + nz*az
  always_ff @(posedge clk) begin
    if (en0) begin
      t0_r     <= tcd_pkg::TERM_W'(in_data.nx) * tcd_pkg::TERM_W'(in_data.dxa);
      t1_r     <= tcd_pkg::TERM_W'(in_data.ny) * tcd_pkg::TERM_W'(in_data.dya);
      t2_r     <= tcd_pkg::TERM_W'(in_data.nz) * tcd_pkg::TERM_W'(in_data.az);
      ins0_r   <= in_data.covered;
      nzz0_r   <= (in_data.nz == '0);
      nzneg0_r <= in_data.nz[tcd_pkg::CROSS_W-1];
      den0_r   <= in_data.nz[tcd_pkg::CROSS_W-1] ? tcd_pkg::DEN_W'(-in_data.nz)
                                                 : tcd_pkg::DEN_W'(in_data.nz);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      num_r    <= tcd_pkg::NUM_W'(t0_r) + tcd_pkg::NUM_W'(t1_r) + tcd_pkg::NUM_W'(t2_r);
      ins1_r   <= ins0_r;
      nzz1_r   <= nzz0_r;
      nzneg1_r <= nzneg0_r;
      den1_r   <= den0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      data_r.covered <= ins1_r;
      data_r.nz_zero <= nzz1_r;
      data_r.neg     <= num_r[tcd_pkg::NUM_W-1] ^ nzneg1_r;
      data_r.num_mag <= num_r[tcd_pkg::NUM_W-1] ? tcd_pkg::MAG_W'(-num_r)
                                                : tcd_pkg::MAG_W'(num_r);
      data_r.den_mag <= den1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en0) begin
        v_r[0] <= in_valid;
      end
      if (en1) begin
        v_r[1] <= v_r[0];
      end
      if (en2) begin
        v_r[2] <= v_r[1];
      end
    end
  end

endmodule

// File: hw/rtl/tcd_div.sv
// Range check stage, then one restoring step per stage, MSB first.
// Saturation and output masking sit after the last step.
module tcd_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tcd_pkg::plane_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tcd_pkg::result_t out_data
);

  localparam int DIV_N = tcd_pkg::Q_W + 1;
  localparam int LAST  = DIV_N - 1;

  logic [tcd_pkg::MAG_W-1:0] rem_r [DIV_N];
  logic [tcd_pkg::DEN_W-1:0] den_r [DIV_N];
  logic [tcd_pkg::Q_W-1:0]   q_r   [DIV_N];
  tcd_pkg::div_flags_t       fl_r  [DIV_N];

  logic [DIV_N-1:0] v_r;
  logic [DIV_N:0]   en;

  assign en[DIV_N]  = out_ready;
  assign in_ready   = en[0];
  assign out_valid  = v_r[LAST];

  for (genvar i = 0; i < DIV_N; i++) begin : g_en
    assign en[i] = !v_r[i] || en[i+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < DIV_N; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // quotient fits Q_W bits only if num < den * 2^Q_W
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]         <= in_data.num_mag;
      den_r[0]         <= in_data.den_mag;
      q_r[0]           <= '0;
      fl_r[0].covered  <= in_data.covered;
      fl_r[0].nz_zero  <= in_data.nz_zero;
      fl_r[0].neg      <= in_data.neg;
      fl_r[0].ovf      <= in_data.num_mag >=
                          (tcd_pkg::MAG_W'(in_data.den_mag) << tcd_pkg::Q_W);
    end
  end

  for (genvar k = 1; k < DIV_N; k++) begin : g_step
    logic [tcd_pkg::MAG_W-1:0] sh;
    logic                      take;

    assign sh   = tcd_pkg::MAG_W'(den_r[k-1]) << (tcd_pkg::Q_W - k);
    assign take = rem_r[k-1] >= sh;

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= take ? (rem_r[k-1] - sh) : rem_r[k-1];
        den_r[k] <= den_r[k-1];
        q_r[k]   <= q_r[k-1] | (take ? (tcd_pkg::Q_W'(1) << (tcd_pkg::Q_W - k))
                                     : tcd_pkg::Q_W'(0));
        fl_r[k]  <= fl_r[k-1];
      end
    end
  end

  logic [tcd_pkg::DEPTH_W-1:0] sat;

  always_comb begin
    if (fl_r[LAST].ovf) begin
      sat = fl_r[LAST].neg ? tcd_pkg::DEPTH_MIN : tcd_pkg::DEPTH_MAX;
    end else if (fl_r[LAST].neg) begin
      sat = (q_r[LAST] > tcd_pkg::DEPTH_MIN) ? tcd_pkg::DEPTH_MIN
                                             : tcd_pkg::DEPTH_W'(-q_r[LAST]);
    end else begin
      sat = (q_r[LAST] > tcd_pkg::DEPTH_MAX) ? tcd_pkg::DEPTH_MAX : q_r[LAST];
    end
    out_data.covered    = fl_r[LAST].covered;
    out_data.degenerate = fl_r[LAST].covered && fl_r[LAST].nz_zero;
    out_data.depth      = (fl_r[LAST].covered && !fl_r[LAST].nz_zero) ? sat : '0;
  end

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[LAST] && !fl_r[LAST].ovf && (den_r[LAST] != '0)
      |-> rem_r[LAST] < tcd_pkg::MAG_W'(den_r[LAST]))
    else $error("divider remainder not below divisor");

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  // Pipeline is 23 deep; wait a bit longer before touching the vertex regs.
  localparam int SETTLE_CYCLES = 30;
  localparam int N_PHASES      = 60;
  localparam int PHASE_ITEMS   = 26;
  // Long receiver stall: starts once this many items went in (no-idle phases).
  localparam int HOLD_AT       = 1300;
  localparam int HOLD_CYCLES   = 300;
  localparam longint LIMIT_NS  = 2_000_000;

  localparam longint DEPTH_HI = 32767;
  localparam longint DEPTH_LO = -32768;

  // Index with no register behind it; writes there must be dropped.
  localparam logic [tcd_pkg::CFG_IDX_W-1:0] REG_UNUSED = tcd_pkg::CFG_IDX_W'(3);

  localparam logic signed [tcd_pkg::FIELD_W-1:0] EXTREMES [5] =
    '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF, 16'sh0001};

  typedef struct packed {
    logic                               covered;
    logic signed [tcd_pkg::DEPTH_W-1:0] depth;
    logic                               degen;
  } cover_t;

  typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [tcd_pkg::CFG_IDX_W-1:0]      index;
    logic [tcd_pkg::CFG_DATA_W-1:0]     data;
    logic signed [tcd_pkg::FIELD_W-1:0] x;
    logic signed [tcd_pkg::FIELD_W-1:0] y;
    logic                               known;   // want holds the typed-in answer
    cover_t                             want;
  } row_t;

  typedef enum {SHAPE_SPAN, SHAPE_CORNER, SHAPE_FLAT, SHAPE_TINY} shape_t;

  // Directed rows. Vertex data is {z, y, x}, each signed Q8.8.
  localparam int N_ROWS = 29;
  localparam row_t DIRECTED [N_ROWS] = '{
    // all vertices zero after reset: zero-area triangle, every point covered, flat normal
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0000, 16'sh0000, 1'b1, '{1'b1, 16'sh0000, 1'b1}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh8000, 16'sh8000, 1'b1, '{1'b1, 16'sh0000, 1'b1}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh7FFF, 16'sh7FFF, 1'b1, '{1'b1, 16'sh0000, 1'b1}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh8000, 16'sh7FFF, 1'b1, '{1'b1, 16'sh0000, 1'b1}},
    // right triangle, flat plane at z = 1.0
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_A, {16'h0100, 16'h0000, 16'h0000}, '0, '0, 1'b0, '0},
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_B, {16'h0100, 16'h0000, 16'h1000}, '0, '0, 1'b0, '0},
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_C, {16'h0100, 16'h1000, 16'h0000}, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0100, 16'sh0100, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh2000, 16'sh2000, 1'b1, '{1'b0, 16'sh0000, 1'b0}},
    // on a vertex, on an edge, on the hypotenuse, just left of the triangle
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0000, 16'sh0000, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0800, 16'sh0000, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0800, 16'sh0800, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'shFFFF, 16'sh0100, 1'b1, '{1'b0, 16'sh0000, 1'b0}},
    // write to the unused index must not disturb anything
    '{ROW_WRITE, REG_UNUSED, 48'hFFFF_FFFF_FFFF, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0100, 16'sh0100, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    // tilted plane with extreme z at a and b
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_A, {16'h7FFF, 16'h0000, 16'h0000}, '0, '0, 1'b0, '0},
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_B, {16'h8000, 16'h0000, 16'h1000}, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0000, 16'sh0000, 1'b1, '{1'b1, 16'sh7FFF, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh1000, 16'sh0000, 1'b1, '{1'b1, 16'sh8000, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0400, 16'sh0400, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh7FFF, 16'sh8000, 1'b1, '{1'b0, 16'sh0000, 1'b0}},
    // collinear vertices: covered points on the line report a flat normal
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_C, {16'h1234, 16'h0000, 16'h2000}, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0800, 16'sh0000, 1'b1, '{1'b1, 16'sh0000, 1'b1}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0800, 16'sh0100, 1'b1, '{1'b0, 16'sh0000, 1'b0}},
    // clockwise winding, negative nz
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_A, {16'h0100, 16'h0000, 16'h0000}, '0, '0, 1'b0, '0},
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_B, {16'h0100, 16'h1000, 16'h0000}, '0, '0, 1'b0, '0},
    '{ROW_WRITE, tcd_pkg::REG_VERTEX_C, {16'h0100, 16'h0000, 16'h1000}, '0, '0, 1'b0, '0},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0100, 16'sh0100, 1'b1, '{1'b1, 16'sh0100, 1'b0}},
    '{ROW_PIXEL, tcd_pkg::REG_VERTEX_A, '0, 16'sh0300, 16'sh0200, 1'b0, '0}
  };

  logic                               clk            = 1'b0;
  logic                               rst_n          = 1'b0;
  logic                               cfg_we         = 1'b0;
  logic [tcd_pkg::CFG_IDX_W-1:0]      cfg_index      = '0;
  logic [tcd_pkg::CFG_DATA_W-1:0]     cfg_data       = '0;
  logic                               in_valid       = 1'b0;
  logic                               in_ready;
  logic signed [tcd_pkg::FIELD_W-1:0] in_pixel_x     = '0;
  logic signed [tcd_pkg::FIELD_W-1:0] in_pixel_y     = '0;
  logic                               out_valid;
  logic                               out_ready      = 1'b0;
  logic                               out_inside_res;
  logic signed [tcd_pkg::DEPTH_W-1:0] out_depth;
  logic                               out_degenerate;

  // Our copy of the vertex registers, indexed like the config port.
  logic [tcd_pkg::CFG_DATA_W-1:0] vertex_reg [3] = '{'0, '0, '0};

  cover_t pending_results [$];
  cover_t head;
  int     err_count     = 0;
  int     items_sent    = 0;
  int     src_idle_pct  = 0;
  int     sink_idle_pct = 0;
  int     hold_left     = 0;
  bit     hold_done     = 1'b0;

  triangle_coverage_depth_top i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_x     (in_pixel_x),
    .in_pixel_y     (in_pixel_y),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_inside_res (out_inside_res),
    .out_depth      (out_depth),
    .out_degenerate (out_degenerate)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sign-extend a packed coordinate from its effective width.
  function automatic longint coord(input logic [tcd_pkg::FIELD_W-1:0] v);
    logic signed [tcd_pkg::EFF_W-1:0] t;
    t = v[tcd_pkg::EFF_W-1:0];
    return longint'(t);
  endfunction

  // Coverage and plane depth of one pixel against the current vertex regs.
  // All math exact in 64 bits; the widest term is well under 60 bits.
  function automatic cover_t coverage_depth(input logic signed [tcd_pkg::FIELD_W-1:0] px_raw,
                                            input logic signed [tcd_pkg::FIELD_W-1:0] py_raw);
    longint ax, ay, az, bx, by, bz, cx, cy, cz, px, py;
    longint d0, d1, d2, nx, ny, nz, num, q;
    cover_t r;
    ax = coord(vertex_reg[tcd_pkg::REG_VERTEX_A][15:0]);
    ay = coord(vertex_reg[tcd_pkg::REG_VERTEX_A][31:16]);
    az = coord(vertex_reg[tcd_pkg::REG_VERTEX_A][47:32]);
    bx = coord(vertex_reg[tcd_pkg::REG_VERTEX_B][15:0]);
    by = coord(vertex_reg[tcd_pkg::REG_VERTEX_B][31:16]);
    bz = coord(vertex_reg[tcd_pkg::REG_VERTEX_B][47:32]);
    cx = coord(vertex_reg[tcd_pkg::REG_VERTEX_C][15:0]);
    cy = coord(vertex_reg[tcd_pkg::REG_VERTEX_C][31:16]);
    cz = coord(vertex_reg[tcd_pkg::REG_VERTEX_C][47:32]);
    px = coord(px_raw);
    py = coord(py_raw);
    // edge functions a->b, b->c, c->a
    d0 = (px - bx) * (ay - by) - (ax - bx) * (py - by);
    d1 = (px - cx) * (by - cy) - (bx - cx) * (py - cy);
    d2 = (px - ax) * (cy - ay) - (cx - ax) * (py - ay);
    r = '0;
    // only mixed signs put the point outside; zeros count as covered
    r.covered = !((d0 < 0 || d1 < 0 || d2 < 0) && (d0 > 0 || d1 > 0 || d2 > 0));
    if (r.covered) begin
      nx = (by - ay) * (cz - az) - (bz - az) * (cy - ay);
      ny = (bz - az) * (cx - ax) - (bx - ax) * (cz - az);
      nz = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
      if (nz == 0) begin
        r.degen = 1'b1;
      end else begin
        num = nx * ax + ny * ay + nz * az - nx * px - ny * py;
        q = num / nz;   // truncates toward zero
        if (q > DEPTH_HI) q = DEPTH_HI;
        if (q < DEPTH_LO) q = DEPTH_LO;
        r.depth = q[tcd_pkg::DEPTH_W-1:0];
      end
    end
    return r;
  endfunction

  // Random coordinate spread over +/- 2^(bits-1).
  function automatic logic signed [tcd_pkg::FIELD_W-1:0] rand_coord(input int bits);
    logic signed [tcd_pkg::FIELD_W-1:0] r;
    r = tcd_pkg::FIELD_W'($urandom);
    return r >>> (tcd_pkg::FIELD_W - bits);
  endfunction

  function automatic logic signed [tcd_pkg::FIELD_W-1:0] clamp16(input longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[tcd_pkg::FIELD_W-1:0];
  endfunction

  // Offer one pixel item; returns on the edge where it is taken. Valid stays
  // high on return so back-to-back items do not drop it.
  task automatic send_pixel(input logic signed [tcd_pkg::FIELD_W-1:0] x,
                            input logic signed [tcd_pkg::FIELD_W-1:0] y,
                            input logic known, input cover_t want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(known ? want : coverage_depth(x, y));
    items_sent++;
  endtask

  // Register write, only once the pipeline has fully drained.
  task automatic apply_write(input logic [tcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcd_pkg::CFG_DATA_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == tcd_pkg::REG_VERTEX_A || idx == tcd_pkg::REG_VERTEX_B ||
        idx == tcd_pkg::REG_VERTEX_C)
      vertex_reg[idx] = value;
  endtask

  // Result side: random backpressure, one long stall, and the compare.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && items_sent >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end

      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: inside_res %0d, depth %0d, degenerate %0d",
                 out_inside_res, out_depth, out_degenerate);
          err_count++;
        end else begin
          head = pending_results.pop_front();
          if (out_inside_res !== head.covered) begin
            $error("inside_res mismatch: expected %0d, got %0d", head.covered, out_inside_res);
            err_count++;
          end
          if (out_depth !== head.depth) begin
            $error("depth mismatch: expected %0d, got %0d", head.depth, out_depth);
            err_count++;
          end
          if (out_degenerate !== head.degen) begin
            $error("degenerate mismatch: expected %0d, got %0d", head.degen, out_degenerate);
            err_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random triangle phases.
  initial begin
    int                                 phase, n, k, span, pick;
    shape_t                             shape;
    logic signed [tcd_pkg::FIELD_W-1:0] vx [3];
    logic signed [tcd_pkg::FIELD_W-1:0] vy [3];
    logic signed [tcd_pkg::FIELD_W-1:0] vz [3];
    logic signed [tcd_pkg::FIELD_W-1:0] ox, oy, qx, qy;
    longint                             wa, wb, wc, jx, jy;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed part with light sender gaps, heavy receiver stalls
    src_idle_pct  = 9;
    sink_idle_pct = 71;
    for (n = 0; n < N_ROWS; n++) begin
      if (DIRECTED[n].kind == ROW_WRITE)
        apply_write(DIRECTED[n].index, DIRECTED[n].data);
      else
        send_pixel(DIRECTED[n].x, DIRECTED[n].y, DIRECTED[n].known, DIRECTED[n].want);
    end

    for (phase = 0; phase < N_PHASES; phase++) begin
      // idle profile: sender light/receiver heavy, then swapped, then none
      if (phase < N_PHASES / 3) begin
        src_idle_pct  = 9;
        sink_idle_pct = 71;
      end else if (phase < 2 * N_PHASES / 3) begin
        src_idle_pct  = 71;
        sink_idle_pct = 9;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end

      case ($urandom_range(0, 7))
        0: shape = SHAPE_CORNER;
        1: shape = SHAPE_FLAT;
        2: shape = SHAPE_TINY;
        default: shape = SHAPE_SPAN;
      endcase

      // span sets the triangle size; tiny ones sit around a random center
      span = $urandom_range(2, 16);
      ox = '0;
      oy = '0;
      if (shape == SHAPE_TINY) begin
        ox   = rand_coord(15);
        oy   = rand_coord(15);
        span = $urandom_range(1, 6);
      end
      // keeps 2b - a in range for the collinear case
      if (shape == SHAPE_FLAT && span > 14) span = 14;

      for (k = 0; k < 3; k++) begin
        vx[k] = ox + rand_coord(span);
        vy[k] = oy + rand_coord(span);
        vz[k] = tcd_pkg::FIELD_W'($urandom);
        if (shape == SHAPE_CORNER) begin
          vx[k] = EXTREMES[$urandom_range(0, 4)];
          vy[k] = EXTREMES[$urandom_range(0, 4)];
          if ($urandom_range(0, 1)) vz[k] = EXTREMES[$urandom_range(0, 4)];
        end
      end
      // zero-area triangle: repeated vertex or c on the line through a, b
      if (shape == SHAPE_FLAT) begin
        if ($urandom_range(0, 1)) begin
          vx[2] = vx[0];
          vy[2] = vy[0];
        end else begin
          vx[2] = tcd_pkg::FIELD_W'(2 * vx[1] - vx[0]);
          vy[2] = tcd_pkg::FIELD_W'(2 * vy[1] - vy[0]);
        end
      end

      apply_write(tcd_pkg::REG_VERTEX_A, {vz[0], vy[0], vx[0]});
      apply_write(tcd_pkg::REG_VERTEX_B, {vz[1], vy[1], vx[1]});
      apply_write(tcd_pkg::REG_VERTEX_C, {vz[2], vy[2], vx[2]});
      if ($urandom_range(0, 3) == 0)
        apply_write(REG_UNUSED, tcd_pkg::CFG_DATA_W'({$urandom, $urandom}));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        case ($urandom_range(0, 9))
          0, 1: begin
            // anywhere at all, mostly outside
            qx = tcd_pkg::FIELD_W'($urandom);
            qy = tcd_pkg::FIELD_W'($urandom);
          end
          default: begin
            // weighted blend of the vertices; some land on an edge or a
            // vertex, jitter pushes others just across an edge
            wa   = $urandom_range(0, 255);
            wb   = $urandom_range(0, 255);
            wc   = $urandom_range(0, 255);
            pick = $urandom_range(0, 7);
            if (pick == 0) wa = 0;
            if (pick == 1) begin
              wa = 0;
              wb = 0;
            end
            if (wa + wb + wc == 0) wc = 1;
            jx = (pick < 2) ? 0 : longint'($urandom_range(0, 2)) - 1;
            jy = (pick < 2) ? 0 : longint'($urandom_range(0, 2)) - 1;
            qx = clamp16((wa * longint'(vx[0]) + wb * longint'(vx[1]) +
                          wc * longint'(vx[2])) / (wa + wb + wc) + jx);
            qy = clamp16((wa * longint'(vy[0]) + wb * longint'(vy[1]) +
                          wc * longint'(vy[2])) / (wa + wb + wc) + jy);
          end
        endcase
        send_pixel(qx, qy, 1'b0, '0);
      end
    end

    // drain, then give the pipeline time to show any stray result
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #(LIMIT_NS);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
